@@ rtl/sfssd_pkg.sv @@
package sfssd_pkg;

    // Frame layout: byte 0 is the header, bytes 1 to 14 carry channels 0 to 9.
    localparam int unsigned LAST_STORED = 14;
    localparam int unsigned POS_SAT     = 15;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned STORE_DEPTH = LAST_STORED - 1;
    localparam int unsigned CH_W        = 11;
    localparam int unsigned NUM_CH      = 10;
    localparam int unsigned STICK_W     = 11;
    localparam int unsigned DEAD_W      = 10;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 11;

    localparam logic signed [STICK_W-1:0] STICK_MAX = 11'sd1023;
    localparam logic signed [STICK_W-1:0] STICK_MIN = -11'sd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_CENTER   = 3'd0,
        CFG_STICK_DEADBAND = 3'd1,
        CFG_SW_LOW_LIMIT   = 3'd2,
        CFG_SW_HIGH_LIMIT  = 3'd3,
        CFG_MIN_VALID      = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SW_DOWN = 2'd0,
        SW_MID  = 2'd1,
        SW_UP   = 2'd2
    } sw_pos_t;

    // Load strobes for the two pipeline stages of a stick lane.
    typedef struct packed {
        logic ld_mid;
        logic ld_out;
    } stick_ctl_t;

    // The down test wins when the limits cross.
    function automatic sw_pos_t sw_classify(input logic [CH_W-1:0] raw,
                                            input logic [CH_W-1:0] lo,
                                            input logic [CH_W-1:0] hi);
        sw_pos_t pos;
        if (raw < lo) begin
            pos = SW_DOWN;
        end else if (raw > hi) begin
            pos = SW_UP;
        end else begin
            pos = SW_MID;
        end
        return pos;
    endfunction

endpackage

@@ rtl/sfssd_stick.sv @@
module sfssd_stick import sfssd_pkg::*; (
    input  logic                      aclk,
    input  stick_ctl_t                ctl,
    input  logic [CH_W-1:0]           raw,
    input  logic [CH_W-1:0]           center,
    input  logic [DEAD_W-1:0]         deadband,
    output logic signed [STICK_W-1:0] stick
);

    // 660/800 equals 33/40. The magnitude is multiplied by 33, shifted right
    // by 3, and then divided by 5 through a reciprocal that is exact for
    // every value below 2^14.
    localparam int unsigned     RECIP_SHIFT = 16;
    localparam int unsigned     X_W         = 14;
    localparam logic [X_W-1:0]  RECIP_K     = 14'd13108;

    logic signed [CH_W:0]       diff;
    logic [CH_W:0]              mag;
    logic [16:0]                times33;
    logic [X_W-1:0]             x_next;
    logic [X_W-1:0]             x_reg;
    logic                       neg_reg;
    logic [2*X_W-1:0]           prod;
    logic [STICK_W-1:0]         quot;
    logic signed [STICK_W-1:0]  stick_next;
    logic signed [STICK_W-1:0]  stick_reg;

    always_comb begin
        diff    = $signed({1'b0, raw}) - $signed({1'b0, center});
        mag     = diff[CH_W] ? (CH_W+1)'(-diff) : (CH_W+1)'(diff);
        times33 = 17'({mag[CH_W-1:0], 5'b0}) + 17'(mag[CH_W-1:0]);
        x_next  = times33[16:3];
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_mid) begin
            x_reg   <= x_next;
            neg_reg <= diff[CH_W];
        end
    end

    always_comb begin
        prod = x_reg * RECIP_K;
        quot = prod[RECIP_SHIFT +: STICK_W];
        if (quot < {1'b0, deadband}) begin
            stick_next = '0;
        end else if (!neg_reg) begin
            stick_next = (quot > 11'd1023) ? STICK_MAX : $signed(quot);
        end else begin
            stick_next = (quot > 11'd1024) ? STICK_MIN : $signed(STICK_W'(-quot));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_out) begin
            stick_reg <= stick_next;
        end
    end

    assign stick = stick_reg;

endmodule

@@ rtl/sbus_frame_stick_switch_decoder.sv @@
// Channel    Direction  Handshake               Payload
// s_ (bytes) in         s_tvalid / s_tready     s_tdata: data_byte; s_tuser: frame_start
// m_ (sticks) out       m_tvalid / m_tready     m_tdata: four sticks, four switches
// cfg_       in         cfg_we (no wait)        cfg_index, cfg_wdata
//
// One byte is accepted per cycle while s_tready is high. A frame's result, captured with
// byte 14, passes on its way to m_ a frame register, a stage that holds the scaled
// stick magnitudes and switch codes, and the result register. The reciprocal
// multiplier of each stick lane sets the stage split.
// Reset is synchronous and active low; it restores the register defaults and
// restarts the byte count. Stalls on m_ back up one stage at a time; s_tready
// drops only while the frame register holds a frame that cannot move on.
module sbus_frame_stick_switch_decoder import sfssd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] data_byte
    input  logic                  s_tuser,    // [0] frame_start

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [10:0] right_horizontal, [21:11] right_vertical, [32:22] left_horizontal,
    // [43:33] left_vertical, [45:44] switch_c, [47:46] switch_a,
    // [49:48] switch_d, [51:50] switch_g, [55:52] zero
    output logic [55:0]           m_tdata,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [CH_W-1:0]   center_reg;
    logic [DEAD_W-1:0] deadband_reg;
    logic [CH_W-1:0]   sw_lo_reg;
    logic [CH_W-1:0]   sw_hi_reg;
    logic [CH_W-1:0]   min_valid_reg;

    // Byte counter and the store for bytes 1 to 13. Byte 14 goes straight
    // into the frame register together with the stored bytes.
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [POS_W-1:0]              idx;
    logic [STORE_DEPTH-1:0][7:0]   store_reg;
    logic [LAST_STORED-1:0][7:0]   frm_reg;
    logic [8*LAST_STORED-1:0]      frm_flat;
    logic [NUM_CH-1:0][CH_W-1:0]   ch;

    // Pipeline valid flags and handshake terms.
    logic        s_acc;
    logic        cap;
    logic        keep;
    logic        frm_vld_reg, frm_vld_next;
    logic        mid_vld_reg, mid_vld_next;
    logic        m_vld_reg, m_vld_next;
    logic        ld_mid, ld_out;
    stick_ctl_t  stick_ctl;

    // Switch codes in the middle and result stages.
    sw_pos_t     sw_c_mid_reg, sw_a_mid_reg, sw_d_mid_reg, sw_g_mid_reg;
    sw_pos_t     sw_c_reg, sw_a_reg, sw_d_reg, sw_g_reg;

    logic signed [STICK_W-1:0] rh, rv, lh, lv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= 11'd1024;
            deadband_reg  <= 10'd50;
            sw_lo_reg     <= 11'd500;
            sw_hi_reg     <= 11'd1500;
            min_valid_reg <= 11'd100;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STICK_CENTER:   center_reg    <= cfg_wdata;
                CFG_STICK_DEADBAND: deadband_reg  <= cfg_wdata[DEAD_W-1:0];
                CFG_SW_LOW_LIMIT:   sw_lo_reg     <= cfg_wdata;
                CFG_SW_HIGH_LIMIT:  sw_hi_reg     <= cfg_wdata;
                CFG_MIN_VALID:      min_valid_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The first byte after reset counts as byte 0 even without a start flag;
    // a start flag always restarts the count. The count sticks at 15, so
    // bytes past 14 are ignored until the next start.
    assign s_acc = s_tvalid & s_tready;
    assign idx   = s_tuser ? '0 : pos_reg;
    assign cap   = s_acc && (idx == POS_W'(LAST_STORED));

    always_comb begin
        pos_next = pos_reg;
        if (s_acc) begin
            pos_next = (idx < POS_W'(POS_SAT)) ? idx + 1'b1 : POS_W'(POS_SAT);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && idx >= 4'd1 && idx < POS_W'(LAST_STORED)) begin
            store_reg[POS_W'(idx - 1'b1)] <= s_tdata;
        end
        if (cap) begin
            frm_reg <= {s_tdata, store_reg};
        end
    end

    // Channels are packed little-endian, 11 bits each, from byte 1 upward.
    assign frm_flat = frm_reg;
    assign ch       = frm_flat[NUM_CH*CH_W-1:0];
    assign keep     = (ch[0] >= min_valid_reg);

    // Each stage moves on when the one after it is empty or moving too.
    assign ld_out   = mid_vld_reg & (~m_vld_reg | m_tready);
    assign ld_mid   = frm_vld_reg & (~mid_vld_reg | ld_out);
    assign s_tready = ~frm_vld_reg | ld_mid;

    assign frm_vld_next = cap | (frm_vld_reg & ~ld_mid);
    assign mid_vld_next = ld_mid ? keep : (mid_vld_reg & ~ld_out);
    assign m_vld_next   = ld_out | (m_vld_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            frm_vld_reg <= 1'b0;
            mid_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            frm_vld_reg <= frm_vld_next;
            mid_vld_reg <= mid_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_mid) begin
            sw_c_mid_reg <= sw_classify(ch[7], sw_lo_reg, sw_hi_reg);
            sw_a_mid_reg <= sw_classify(ch[9], sw_lo_reg, sw_hi_reg);
            sw_d_mid_reg <= sw_classify(ch[6], sw_lo_reg, sw_hi_reg);
            sw_g_mid_reg <= sw_classify(ch[4], sw_lo_reg, sw_hi_reg);
        end
        if (ld_out) begin
            sw_c_reg <= sw_c_mid_reg;
            sw_a_reg <= sw_a_mid_reg;
            sw_d_reg <= sw_d_mid_reg;
            sw_g_reg <= sw_g_mid_reg;
        end
    end

    assign stick_ctl.ld_mid = ld_mid;
    assign stick_ctl.ld_out = ld_out;

    sfssd_stick u_right_h (
        .aclk(aclk), .ctl(stick_ctl), .raw(ch[0]), .center(center_reg),
        .deadband(deadband_reg), .stick(rh)
    );
    sfssd_stick u_right_v (
        .aclk(aclk), .ctl(stick_ctl), .raw(ch[1]), .center(center_reg),
        .deadband(deadband_reg), .stick(rv)
    );
    sfssd_stick u_left_h (
        .aclk(aclk), .ctl(stick_ctl), .raw(ch[3]), .center(center_reg),
        .deadband(deadband_reg), .stick(lh)
    );
    sfssd_stick u_left_v (
        .aclk(aclk), .ctl(stick_ctl), .raw(ch[2]), .center(center_reg),
        .deadband(deadband_reg), .stick(lv)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {4'b0, sw_g_reg, sw_d_reg, sw_a_reg, sw_c_reg, lv, lh, rv, rh};

    // A frame whose channel 0 is under the minimum never reaches the
    // middle stage.
    a_drop_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_mid && !keep) |=> !mid_vld_reg)
        else $error("dropped frame entered the middle stage");

    // A new result is only ever loaded from a filled middle stage.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_vld_reg) |-> $past(mid_vld_reg))
        else $error("result appeared without a middle-stage request");

    // Backpressure on the input comes only from a held frame register.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (frm_vld_reg && mid_vld_reg))
        else $error("input stalled with room in the pipeline");

    // A byte with the start flag is byte 0, so the next byte is byte 1.
    a_start_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser) |=> (pos_reg == 4'd1))
        else $error("start flag did not restart the byte count");

endmodule
